// ----- hw/rtl/kvt_pkg.sv -----
package kvt_pkg;

  // Fixed field widths of the request and result.
  localparam int unsigned KEY_W    = 24;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // Request op codes.
  localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL  = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

  // Summary flags that the scan unit reports to the controller.
  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

// ----- hw/rtl/kvt_ram.sv -----
module kvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/kvt_scan.sv -----
module kvt_scan #(
  parameter int unsigned AW = 6,
  parameter int unsigned SK = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 en_i,
  input  logic [AW-1:0]        idx_i,
  input  logic                 entry_valid_i,
  input  logic [SK-1:0]        entry_key_i,
  input  logic [SK-1:0]        key_i,
  output kvt_pkg::scan_flags_t flags_o,
  output logic [AW-1:0]        hit_idx_o,
  output logic [AW-1:0]        free_idx_o
);
  import kvt_pkg::*;

  scan_flags_t   flags_q, flags_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          match;

  // One compare per cycle: the entry that the RAM returned against the request key.
  assign match = entry_valid_i && (entry_key_i == key_i);

  // Keep the first matching slot and the lowest free slot seen so far.
  always_comb begin
    flags_d    = flags_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    if (clear_i) begin
      flags_d = '0;
    end else if (en_i) begin
      if (match && !flags_q.hit) begin
        flags_d.hit = 1'b1;
        hit_idx_d   = idx_i;
      end
      if (!entry_valid_i && !flags_q.free) begin
        flags_d.free = 1'b1;
        free_idx_d   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign flags_o    = flags_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

// ----- hw/rtl/key_value_table_add_del_find.sv -----
// A request transfer starts a scan of every slot; S_TAIL and S_DECIDE then follow, and the
// result's strobe is registered out of S_DECIDE, or out of S_FETCH for a find that hits. busy
// falls as the strobe rises, so the next transfer can happen at the edge that ends the strobe.
// The scan is linear over the key RAM, one slot per cycle through one comparator.
// After reset a clearing pass marks every slot invalid while busy is high.
// Results are shown for one cycle under result_valid_o; the receiver cannot stall them.
module key_value_table_add_del_find #(
  parameter int unsigned ENTRIES  = 64,
  parameter int unsigned KEY_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [kvt_pkg::OP_W-1:0]          op_i,
  input  logic [kvt_pkg::KEY_W-1:0]         key_i,
  input  logic [kvt_pkg::VALUE_W-1:0]       value_i,
  output logic                              result_valid_o,
  output logic [kvt_pkg::STATUS_W-1:0]      status_o,
  output logic [kvt_pkg::VALUE_W-1:0]       found_value_o
);
  import kvt_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned SK = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_TAIL   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_FETCH  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       addr_q, addr_d;
  logic                cmp_en_q;
  logic [AW-1:0]       cmp_idx_q;
  logic [OP_W-1:0]     op_q;
  logic [SK-1:0]       key_q;
  logic [VALUE_W-1:0]  value_q;
  logic                accept;

  logic                valid_q, valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  found_q, found_d;

  logic                kwe;
  logic [AW-1:0]       kwaddr;
  logic [SK:0]         kwdata;
  logic [SK:0]         krdata;
  logic                vwe;
  logic [AW-1:0]       vwaddr;
  logic [VALUE_W-1:0]  vrdata;

  scan_flags_t         flags;
  logic [AW-1:0]       hit_idx;
  logic [AW-1:0]       free_idx;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Key store: the top bit of each word is the slot's valid flag.
  kvt_ram #(
    .WIDTH (SK + 1),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (kwaddr),
    .wdata_i (kwdata),
    .raddr_i (addr_q),
    .rdata_o (krdata)
  );

  // Value store; its read data is used only for a find that hits.
  kvt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vwe),
    .waddr_i (vwaddr),
    .wdata_i (value_q),
    .raddr_i (hit_idx),
    .rdata_o (vrdata)
  );

  // Shared compare unit that walks the slots.
  kvt_scan #(
    .AW (AW),
    .SK (SK)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (accept),
    .en_i          (cmp_en_q),
    .idx_i         (cmp_idx_q),
    .entry_valid_i (krdata[SK]),
    .entry_key_i   (krdata[SK-1:0]),
    .key_i         (key_q),
    .flags_o       (flags),
    .hit_idx_o     (hit_idx),
    .free_idx_o    (free_idx)
  );

  // Sequencer: clear after reset, scan, then act on the scan result.
  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    kwe      = 1'b0;
    kwaddr   = addr_q;
    kwdata   = '0;
    vwe      = 1'b0;
    vwaddr   = hit_idx;
    valid_d  = 1'b0;
    status_d = status_q;
    found_d  = found_q;
    case (state_q)
      S_CLEAR: begin
        kwe = 1'b1;
        if (addr_q == LAST) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_IDLE: begin
        addr_d = '0;
        if (accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr_q == LAST) begin
          addr_d  = '0;
          state_d = S_TAIL;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_TAIL: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d  = S_IDLE;
        valid_d  = 1'b1;
        status_d = ST_DONE;
        found_d  = '0;
        case (op_q)
          OP_ADD: begin
            if (flags.hit) begin
              vwe    = 1'b1;
              vwaddr = hit_idx;
            end else if (flags.free) begin
              kwe    = 1'b1;
              kwaddr = free_idx;
              kwdata = {1'b1, key_q};
              vwe    = 1'b1;
              vwaddr = free_idx;
            end else begin
              status_d = ST_FULL;
            end
          end
          OP_DEL: begin
            if (flags.hit) begin
              kwe    = 1'b1;
              kwaddr = hit_idx;
            end
          end
          OP_FIND: begin
            if (flags.hit) begin
              valid_d = 1'b0;
              state_d = S_FETCH;
            end else begin
              status_d = ST_MISS;
            end
          end
          default: begin
            status_d = ST_DONE;
          end
        endcase
      end
      S_FETCH: begin
        state_d  = S_IDLE;
        valid_d  = 1'b1;
        status_d = ST_FOUND;
        found_d  = vrdata;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      addr_q   <= '0;
      cmp_en_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      addr_q   <= addr_d;
      cmp_en_q <= (state_q == S_SCAN);
      valid_q  <= valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= addr_q;
    status_q  <= status_d;
    found_q   <= found_d;
    if (accept) begin
      op_q    <= op_i;
      key_q   <= key_i[SK-1:0];
      value_q <= value_i;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign found_value_o  = found_q;

endmodule
